@@ src/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types and fixed constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      S_INIT,   // clearing pass over the cell store after reset
      S_IDLE,   // waiting for a request transaction
      S_READ,   // cell read data arrives from the store
      S_COPY,   // scroll: move every row up by one
      S_ZERO,   // zero a range of cells (clear screen, last row after scroll)
      S_DONE    // hand the result to the response register
   } state_type;

   // Request opcodes
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Character and attribute constants
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] ATTR_RESET   = 8'h0F;

   // Field widths
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int OUT_COL_W = 7;
   localparam int OUT_ROW_W = 5;
   localparam int IN_ROW_W  = 5;
   localparam int IN_COL_W  = 7;

endpackage

`default_nettype wire

@@ src/text_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// Text console writer unit
// Text-mode console engine over a character/attribute cell store.
// ----------------------------------------------------------------------------
// Usage:
//   Request transactions arrive on req_* (opcode in req_tuser, character and
//   read coordinates in req_tdata); each one yields exactly one response
//   transaction on rsp_* carrying the cursor, the scroll flag and, for reads,
//   the cell. The attribute register is written through csr_wr_en and
//   csr_wr_data; the user must write it only while the unit is idle, as
//   the unit itself does no such check. Transaction length is set by the
//   single write and single read port of the cell store. A put character
//   writes the cell (a newline writes none) and, on a scroll, runs a copy
//   sweep and then zeroes the last row; a read cell reads one cell from
//   the store; a clear screen zeroes every cell.
//   After reset the cell store is cleared, one cell per cycle, and req_tready
//   stays low during that pass.
//   The response register holds a finished result while rsp_tready is low;
//   the next request is accepted meanwhile, and its own result waits in the
//   done state until the response register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   input  wire logic [23:0] req_tdata,   // [7:0] char_code, [12:8] read_row,
                                         // [19:13] read_column, [23:20] zero
   // Response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [6:0] cursor_col, [11:7] cursor_line,
                                         // [12] scrolled, [20:13] cell_char,
                                         // [28:21] cell_attr, [31:29] zero
   // Attribute register
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   localparam int DEPTH         = ROWS * COLUMNS;
   localparam int COL_W         = $clog2(COLUMNS);
   localparam int ROW_W         = $clog2(ROWS);
   localparam int ADDR_W        = $clog2(DEPTH);
   localparam int PTR_W         = $clog2(DEPTH + 1);
   localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

   localparam logic [COL_W-1:0]  COL_MAX    = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_MAX    = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
   localparam logic [PTR_W-1:0]  PTR_COLS   = PTR_W'(COLUMNS);
   localparam logic [PTR_W-1:0]  PTR_DEPTH  = PTR_W'(DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W-1:0]  PTR_LROW   = PTR_W'(LAST_ROW_BASE);
   localparam logic [PTR_W-1:0]  PTR_BACK   = PTR_W'(COLUMNS + 1);

   // Registers
   tcw_pkg::state_type     state_ff, state_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [7:0]             attr_ff, attr_in;
   logic                   read_hit_ff, read_hit_in;
   logic                   res_scrolled_ff, res_scrolled_in;
   logic [7:0]             res_char_ff, res_char_in;
   logic [7:0]             res_attr_ff, res_attr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_data_ff, rsp_data_in;
   logic [15:0]            mem_rd_data_ff;

   // Cell store: character in the low byte, attribute in the high byte
   logic [15:0]            cell_store [DEPTH];

   // Store port controls
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [15:0]            mem_wr_data;
   logic                   mem_re;
   logic [ADDR_W-1:0]      mem_rd_addr;

   // Request fields
   logic [1:0]             in_opcode;
   logic [7:0]             in_char;
   logic [4:0]             in_row;
   logic [6:0]             in_col;

   logic                   accept;
   logic                   out_free;
   logic                   rsp_load;
   logic                   is_newline;
   logic                   wrap;
   logic                   need_scroll;
   logic                   read_in_range;
   logic [ADDR_W-1:0]      cursor_addr;
   logic [ADDR_W-1:0]      read_addr;
   logic [PTR_W-1:0]       copy_dst;

   assign in_opcode = req_tuser;
   assign in_char   = req_tdata[7:0];
   assign in_row    = req_tdata[12:8];
   assign in_col    = req_tdata[19:13];

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = (state_ff == tcw_pkg::S_DONE) && out_free;

   // Cursor movement of a put-character transaction
   assign is_newline  = (in_char == tcw_pkg::NEWLINE_CODE);
   assign wrap        = is_newline || (col_ff == COL_MAX);
   assign need_scroll = wrap && (row_ff == ROW_MAX);

   assign read_in_range = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLUMNS));

   assign cursor_addr = ADDR_W'(row_ff) * COLS_A + ADDR_W'(col_ff);
   assign read_addr   = ADDR_W'(in_row) * COLS_A + ADDR_W'(in_col);
   assign copy_dst    = ptr_ff - PTR_BACK;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::S_INIT: begin
            if (ptr_ff == PTR_LAST) state_in = tcw_pkg::S_IDLE;
         end
         tcw_pkg::S_IDLE: begin
            if (accept) begin
               case (in_opcode)
                  tcw_pkg::OP_PUT:   state_in = need_scroll ? tcw_pkg::S_COPY
                                                            : tcw_pkg::S_DONE;
                  tcw_pkg::OP_CLEAR: state_in = tcw_pkg::S_ZERO;
                  tcw_pkg::OP_READ:  state_in = tcw_pkg::S_READ;
                  default:           state_in = tcw_pkg::S_DONE;
               endcase
            end
         end
         tcw_pkg::S_READ: state_in = tcw_pkg::S_DONE;
         tcw_pkg::S_COPY: begin
            if (ptr_ff == PTR_DEPTH) state_in = tcw_pkg::S_ZERO;
         end
         tcw_pkg::S_ZERO: begin
            if (ptr_ff == PTR_LAST) state_in = tcw_pkg::S_DONE;
         end
         tcw_pkg::S_DONE: begin
            if (out_free) state_in = tcw_pkg::S_IDLE;
         end
         default: state_in = tcw_pkg::S_INIT;
      endcase
   end

   // Outputs: handshake and store ports
   always_comb begin
      req_tready  = (state_ff == tcw_pkg::S_IDLE);
      mem_we      = 1'b0;
      mem_wr_addr = ptr_ff[ADDR_W-1:0];
      mem_wr_data = '0;
      mem_re      = 1'b0;
      mem_rd_addr = ptr_ff[ADDR_W-1:0];
      case (state_ff)
         tcw_pkg::S_INIT, tcw_pkg::S_ZERO: begin
            mem_we = 1'b1;
         end
         tcw_pkg::S_IDLE: begin
            if (accept && (in_opcode == tcw_pkg::OP_PUT) && !is_newline) begin
               mem_we      = 1'b1;
               mem_wr_addr = cursor_addr;
               mem_wr_data = {attr_ff, in_char};
            end
            if (accept && (in_opcode == tcw_pkg::OP_READ) && read_in_range) begin
               mem_re      = 1'b1;
               mem_rd_addr = read_addr;
            end
         end
         tcw_pkg::S_COPY: begin
            // read one row ahead, write back what the previous cycle fetched
            mem_re      = (ptr_ff < PTR_DEPTH);
            mem_we      = (ptr_ff > PTR_COLS);
            mem_wr_addr = copy_dst[ADDR_W-1:0];
            mem_wr_data = mem_rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      ptr_in          = ptr_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      read_hit_in     = read_hit_ff;
      res_scrolled_in = res_scrolled_ff;
      res_char_in     = res_char_ff;
      res_attr_in     = res_attr_ff;
      attr_in         = csr_wr_en ? csr_wr_data : attr_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      case (state_ff)
         tcw_pkg::S_INIT, tcw_pkg::S_ZERO: begin
            ptr_in = ptr_ff + PTR_W'(1);
         end
         tcw_pkg::S_IDLE: begin
            if (accept) begin
               res_scrolled_in = 1'b0;
               res_char_in     = '0;
               res_attr_in     = '0;
               read_hit_in     = 1'b0;
               case (in_opcode)
                  tcw_pkg::OP_PUT: begin
                     if (wrap) begin
                        col_in = '0;
                        if (row_ff == ROW_MAX) begin
                           res_scrolled_in = 1'b1;
                           ptr_in          = PTR_COLS;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                        end
                     end else begin
                        col_in = col_ff + COL_W'(1);
                     end
                  end
                  tcw_pkg::OP_CLEAR: begin
                     col_in = '0;
                     row_in = '0;
                     ptr_in = '0;
                  end
                  tcw_pkg::OP_READ: begin
                     read_hit_in = read_in_range;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tcw_pkg::S_READ: begin
            res_char_in = read_hit_ff ? mem_rd_data_ff[7:0]  : 8'd0;
            res_attr_in = read_hit_ff ? mem_rd_data_ff[15:8] : 8'd0;
         end
         tcw_pkg::S_COPY: begin
            ptr_in = (ptr_ff == PTR_DEPTH) ? PTR_LROW : ptr_ff + PTR_W'(1);
         end
         tcw_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'd0, res_attr_ff, res_char_ff, res_scrolled_ff,
                               tcw_pkg::OUT_ROW_W'(row_ff),
                               tcw_pkg::OUT_COL_W'(col_ff)};
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::S_INIT;
         ptr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      read_hit_ff     <= read_hit_in;
      res_scrolled_ff <= res_scrolled_in;
      res_char_ff     <= res_char_in;
      res_attr_ff     <= res_attr_in;
      rsp_data_ff     <= rsp_data_in;
   end

   // Cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_store[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_re) begin
         mem_rd_data_ff <= cell_store[mem_rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Assertions
   a_port_conflict : assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_wr_addr != mem_rd_addr))
      else $error("cell store read and write hit the same cell");

   a_cursor_range : assert property (@(posedge clock) disable iff (reset)
      (col_ff <= COL_MAX) && (row_ff <= ROW_MAX))
      else $error("cursor outside the screen");

   a_clear_sweep : assert property (@(posedge clock) disable iff (reset)
      (accept && (in_opcode == tcw_pkg::OP_CLEAR)) |=>
         (state_ff == tcw_pkg::S_ZERO) && (ptr_ff == '0))
      else $error("clear did not start a zeroing sweep from cell zero");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tcw_pkg::S_DONE))
      else $error("response raised outside the done state");

endmodule

`default_nettype wire
